### rtl/core/fpl_pkg.sv
// Shared types and constants for the frame plane layout block.
`timescale 1ns / 1ps

package fpl_pkg;

  // Input dimension width and padded dimension width (one extra bit of headroom)
  localparam int unsigned DIM_W = 13;
  localparam int unsigned PAD_W = DIM_W + 1;

  // Result field widths
  localparam int unsigned STRIDE_W = 15;
  localparam int unsigned CSTR_W   = 13;
  localparam int unsigned OFF1_W   = 25;
  localparam int unsigned OFF2_W   = 26;
  localparam int unsigned SIZE_W   = 27;

  localparam int unsigned FMT_W = 3;

  typedef enum logic [FMT_W-1:0] {
    FMT_ARGB    = 3'd0,
    FMT_YUYV    = 3'd1,
    FMT_YVYU    = 3'd2,
    FMT_YUV444  = 3'd3,
    FMT_YUV422P = 3'd4,
    FMT_YUV420  = 3'd5
  } fmt_e;

  localparam logic ST_OK      = 1'b0;
  localparam logic ST_BAD_FMT = 1'b1;

  // Load strobes for the two register stages of the padding unit
  typedef struct packed {
    logic ld_quot;
    logic ld_pad;
  } pad_ld_t;

endpackage

### rtl/core/fpl_pad.sv
// Two-stage unit that rounds a dimension up to a multiple of ALIGN.
`timescale 1ns / 1ps

module fpl_pad #(
  parameter int unsigned ALIGN = 64
) (
  input  logic                      clk_i,
  input  fpl_pkg::pad_ld_t          ld_i,
  input  logic [fpl_pkg::DIM_W-1:0] len_i,
  output logic [fpl_pkg::PAD_W-1:0] pad_o
);

  // Quotient by multiply with a rounded-up reciprocal; exact for any numerator
  // below 2**NUM_W.
  localparam int unsigned NUM_W  = fpl_pkg::PAD_W;
  localparam int unsigned SHIFT  = NUM_W + $clog2(ALIGN);
  localparam int unsigned RCP_W  = NUM_W + 2;
  localparam int unsigned PROD_W = NUM_W + RCP_W;
  localparam logic [RCP_W-1:0] RECIP = RCP_W'(((64'd1 << SHIFT) + ALIGN - 1) / ALIGN);
  localparam logic [NUM_W-1:0] ROUND = NUM_W'(ALIGN - 1);
  localparam logic [fpl_pkg::PAD_W-1:0] ALIGN_V = fpl_pkg::PAD_W'(ALIGN);

  logic [NUM_W-1:0]          num;
  logic [PROD_W-1:0]         prod;
  logic [NUM_W-1:0]          quot_d, quot_q;
  logic [fpl_pkg::PAD_W-1:0] pad_d, pad_q;

  always_comb begin
    num    = NUM_W'(len_i) + ROUND;
    prod   = PROD_W'(num) * PROD_W'(RECIP);
    quot_d = NUM_W'(prod >> SHIFT);
    pad_d  = quot_q * ALIGN_V;
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.ld_quot) begin
      quot_q <= quot_d;
    end
    if (ld_i.ld_pad) begin
      pad_q <= pad_d;
    end
  end

  assign pad_o = pad_q;

endmodule

### rtl/core/frame_plane_layout_top.sv
// Top level: pipelined frame buffer layout calculator.
// A request passes saturate and decode, area products, tight size, strides, plane areas and the output register.
// Throughput: one request per cycle while the output is not stalled; stages are sized around one multiply each.
// Stalls ripple back stage by stage, so empty stages still fill while output waits.
// Reset clears only the stage valid bits; data registers are loaded as items pass.
// Unknown format codes return status 1 with every data field zero.
`timescale 1ns / 1ps

module frame_plane_layout_top #(
  parameter int unsigned ALIGN   = 64,
  parameter int unsigned MAX_DIM = 4096
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [12:0] frame_width, [25:13] frame_height, [31:26] zero
  input  logic [31:0]  s_axis_tdata,
  // [2:0] pixel_format
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [12:0] padded_height, [25:13] chroma_width, [38:26] chroma_height,
  // [53:39] luma_stride, [66:54] first_chroma_stride, [79:67] second_chroma_stride,
  // [104:80] first_chroma_offset, [130:105] second_chroma_offset,
  // [157:131] padded_size, [184:158] tight_size, [191:185] zero
  output logic [191:0] m_axis_tdata,
  // [0] status, [1] tight_valid
  output logic [1:0]   m_axis_tuser
);

  localparam int unsigned DIM_W  = fpl_pkg::DIM_W;
  localparam int unsigned PAD_W  = fpl_pkg::PAD_W;
  localparam int unsigned S0_W   = PAD_W + 2;
  localparam int unsigned WH_W   = 2 * DIM_W;
  localparam int unsigned OFF_W  = S0_W + PAD_W;
  localparam int unsigned T_W    = 2 * PAD_W;
  localparam int unsigned SIZE_W = fpl_pkg::SIZE_W;
  localparam int unsigned SAT_DIM = (MAX_DIM > (2**DIM_W - 1)) ? (2**DIM_W - 1) : MAX_DIM;
  localparam logic [DIM_W-1:0] SAT_V = DIM_W'(SAT_DIM);

  // ---------------- handshake chain ----------------
  logic v1_q, v2_q, v3_q, v4_q, v5_q, v6_q;
  logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

  assign rdy6 = !v6_q || m_axis_tready;
  assign rdy5 = !v5_q || rdy6;
  assign rdy4 = !v4_q || rdy5;
  assign rdy3 = !v3_q || rdy4;
  assign rdy2 = !v2_q || rdy3;
  assign rdy1 = !v1_q || rdy2;

  assign s_axis_tready = rdy1;
  assign m_axis_tvalid = v6_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
      v5_q <= 1'b0;
      v6_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= s_axis_tvalid;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy4) v4_q <= v3_q;
      if (rdy5) v5_q <= v4_q;
      if (rdy6) v6_q <= v5_q;
    end
  end

  logic ld1, ld2, ld3, ld4, ld5, ld6;
  assign ld1 = rdy1 && s_axis_tvalid;
  assign ld2 = rdy2 && v1_q;
  assign ld3 = rdy3 && v2_q;
  assign ld4 = rdy4 && v3_q;
  assign ld5 = rdy5 && v4_q;
  assign ld6 = rdy6 && v5_q;

  // ---------------- stage 1: saturate, decode ----------------
  logic [DIM_W-1:0] w_in, h_in;
  fpl_pkg::fmt_e    fmt_in;
  logic [DIM_W-1:0] w1_d, h1_d, w1_q, h1_q;
  fpl_pkg::fmt_e    fmt1_q;
  logic             bad1_d, bad1_q, tv1_d, tv1_q;

  always_comb begin
    w_in   = s_axis_tdata[DIM_W-1:0];
    h_in   = s_axis_tdata[2*DIM_W-1:DIM_W];
    fmt_in = fpl_pkg::fmt_e'(s_axis_tuser);
    w1_d   = (w_in > SAT_V) ? SAT_V : w_in;
    h1_d   = (h_in > SAT_V) ? SAT_V : h_in;
    bad1_d = !(fmt_in inside {fpl_pkg::FMT_ARGB, fpl_pkg::FMT_YUYV, fpl_pkg::FMT_YVYU,
                              fpl_pkg::FMT_YUV444, fpl_pkg::FMT_YUV422P,
                              fpl_pkg::FMT_YUV420});
    tv1_d  = (fmt_in inside {fpl_pkg::FMT_ARGB, fpl_pkg::FMT_YUV444,
                             fpl_pkg::FMT_YUV422P, fpl_pkg::FMT_YUV420})
             && (w1_d != '0) && (h1_d != '0);
  end

  always_ff @(posedge clk_i) begin
    if (ld1) begin
      w1_q   <= w1_d;
      h1_q   <= h1_d;
      fmt1_q <= fmt_in;
      bad1_q <= bad1_d;
      tv1_q  <= tv1_d;
    end
  end

  // ---------------- padding units (stages 2 and 3) ----------------
  fpl_pkg::pad_ld_t pad_ld;
  logic [PAD_W-1:0] pw3, ph3;

  assign pad_ld.ld_quot = ld2;
  assign pad_ld.ld_pad  = ld3;

  fpl_pad #(.ALIGN(ALIGN)) u_pad_w (
    .clk_i (clk_i),
    .ld_i  (pad_ld),
    .len_i (w1_q),
    .pad_o (pw3)
  );

  fpl_pad #(.ALIGN(ALIGN)) u_pad_h (
    .clk_i (clk_i),
    .ld_i  (pad_ld),
    .len_i (h1_q),
    .pad_o (ph3)
  );

  // ---------------- stage 2: area products ----------------
  logic [WH_W-1:0]  wh2_d, wh2_q, c2_d, c2_q;
  logic [DIM_W-1:0] half_h, cw2_d, cw2_q;
  fpl_pkg::fmt_e    fmt2_q;
  logic             bad2_q, tv2_q;

  always_comb begin
    half_h = (fmt1_q == fpl_pkg::FMT_YUV420) ? (h1_q >> 1) : h1_q;
    wh2_d  = WH_W'(w1_q) * WH_W'(h1_q);
    c2_d   = WH_W'(w1_q >> 1) * WH_W'(half_h);
    case (fmt1_q)
      fpl_pkg::FMT_YUV444:                      cw2_d = w1_q;
      fpl_pkg::FMT_YUV422P, fpl_pkg::FMT_YUV420: cw2_d = w1_q >> 1;
      default:                                  cw2_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld2) begin
      wh2_q  <= wh2_d;
      c2_q   <= c2_d;
      cw2_q  <= cw2_d;
      fmt2_q <= fmt1_q;
      bad2_q <= bad1_q;
      tv2_q  <= tv1_q;
    end
  end

  // ---------------- stage 3: tight size ----------------
  logic [SIZE_W-1:0] tight3_d, tight3_q;
  logic [DIM_W-1:0]  cw3_q;
  fpl_pkg::fmt_e     fmt3_q;
  logic              bad3_q, tv3_q;

  always_comb begin
    case (fmt2_q)
      fpl_pkg::FMT_ARGB:   tight3_d = SIZE_W'({wh2_q, 2'b00});
      fpl_pkg::FMT_YUV444: tight3_d = SIZE_W'(wh2_q) + SIZE_W'({wh2_q, 1'b0});
      fpl_pkg::FMT_YUV422P, fpl_pkg::FMT_YUV420:
                           tight3_d = SIZE_W'(wh2_q) + SIZE_W'({c2_q, 1'b0});
      default:             tight3_d = '0;
    endcase
    if (!tv2_q) begin
      tight3_d = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld3) begin
      tight3_q <= tight3_d;
      cw3_q    <= cw2_q;
      fmt3_q   <= fmt2_q;
      bad3_q   <= bad2_q;
      tv3_q    <= tv2_q;
    end
  end

  // ---------------- stage 4: strides and chroma height ----------------
  logic [S0_W-1:0]   s0_4_d, s0_4_q;
  logic [PAD_W-1:0]  s1_4_d, s1_4_q, ch4_d, ch4_q, hp4_q;
  logic              planar4_d, planar4_q;
  logic [SIZE_W-1:0] tight4_q;
  logic [DIM_W-1:0]  cw4_q;
  logic              bad4_q, tv4_q;

  always_comb begin
    s0_4_d    = S0_W'(pw3);
    s1_4_d    = '0;
    ch4_d     = '0;
    planar4_d = 1'b0;
    case (fmt3_q)
      fpl_pkg::FMT_ARGB: begin
        s0_4_d = S0_W'({pw3, 2'b00});
      end
      fpl_pkg::FMT_YUYV, fpl_pkg::FMT_YVYU: begin
        s0_4_d = S0_W'({pw3, 1'b0});
      end
      fpl_pkg::FMT_YUV444: begin
        s1_4_d    = pw3;
        ch4_d     = ph3;
        planar4_d = 1'b1;
      end
      fpl_pkg::FMT_YUV422P: begin
        s1_4_d    = pw3 >> 1;
        ch4_d     = ph3;
        planar4_d = 1'b1;
      end
      fpl_pkg::FMT_YUV420: begin
        s1_4_d    = pw3 >> 1;
        ch4_d     = ph3 >> 1;
        planar4_d = 1'b1;
      end
      default: begin
        s0_4_d = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (ld4) begin
      s0_4_q    <= s0_4_d;
      s1_4_q    <= s1_4_d;
      ch4_q     <= ch4_d;
      hp4_q     <= ph3;
      planar4_q <= planar4_d;
      tight4_q  <= tight3_q;
      cw4_q     <= cw3_q;
      bad4_q    <= bad3_q;
      tv4_q     <= tv3_q;
    end
  end

  // ---------------- stage 5: plane areas ----------------
  logic [OFF_W-1:0]  off1_5_d, off1_5_q;
  logic [T_W-1:0]    t5_d, t5_q;
  logic [S0_W-1:0]   s0_5_q;
  logic [PAD_W-1:0]  s1_5_q, ch5_q, hp5_q;
  logic              planar5_q;
  logic [SIZE_W-1:0] tight5_q;
  logic [DIM_W-1:0]  cw5_q;
  logic              bad5_q, tv5_q;

  always_comb begin
    off1_5_d = OFF_W'(s0_4_q) * OFF_W'(hp4_q);
    t5_d     = T_W'(s1_4_q) * T_W'(ch4_q);
  end

  always_ff @(posedge clk_i) begin
    if (ld5) begin
      off1_5_q  <= off1_5_d;
      t5_q      <= t5_d;
      s0_5_q    <= s0_4_q;
      s1_5_q    <= s1_4_q;
      ch5_q     <= ch4_q;
      hp5_q     <= hp4_q;
      planar5_q <= planar4_q;
      tight5_q  <= tight4_q;
      cw5_q     <= cw4_q;
      bad5_q    <= bad4_q;
      tv5_q     <= tv4_q;
    end
  end

  // ---------------- stage 6: offsets, size, output register ----------------
  logic [fpl_pkg::OFF1_W-1:0] off1_o;
  logic [fpl_pkg::OFF2_W-1:0] off2_o;
  logic [SIZE_W-1:0]          size_o;
  logic [191:0]               tdata_d, tdata_q;
  logic [1:0]                 tuser_d, tuser_q;

  always_comb begin
    // For 4:4:4 the second chroma plane area equals the luma area, so all
    // planar cases share off1 + t.
    off1_o = planar5_q ? fpl_pkg::OFF1_W'(off1_5_q) : '0;
    off2_o = planar5_q ? (fpl_pkg::OFF2_W'(off1_5_q) + fpl_pkg::OFF2_W'(t5_q)) : '0;
    size_o = SIZE_W'(off1_5_q) + SIZE_W'({t5_q, 1'b0});
    tdata_d = {7'd0,
               tight5_q,
               size_o,
               off2_o,
               off1_o,
               fpl_pkg::CSTR_W'(s1_5_q),
               fpl_pkg::CSTR_W'(s1_5_q),
               fpl_pkg::STRIDE_W'(s0_5_q),
               DIM_W'(ch5_q),
               cw5_q,
               DIM_W'(hp5_q)};
    tuser_d = {tv5_q, fpl_pkg::ST_OK};
    if (bad5_q) begin
      tdata_d = '0;
      tuser_d = {1'b0, fpl_pkg::ST_BAD_FMT};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld6) begin
      tdata_q <= tdata_d;
      tuser_q <= tuser_d;
    end
  end

  assign m_axis_tdata = tdata_q;
  assign m_axis_tuser = tuser_q;

  // ---------------- assertions ----------------
  a_bad_fmt_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser[0] == fpl_pkg::ST_BAD_FMT) |-> (m_axis_tdata == '0))
    else $error("unknown format result carries nonzero data");

  a_tight_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[1] |-> (m_axis_tuser[0] == fpl_pkg::ST_OK))
    else $error("tight_valid set on an error result");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready |-> (v1_q && v2_q && v3_q && v4_q && v5_q && m_axis_tvalid
                        && !m_axis_tready))
    else $error("input stalled while the pipeline has room");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v5_q && !rdy6 |=> v5_q)
    else $error("stage 5 item lost during output stall");

endmodule

### test/frame_plane_layout_top_tb.sv
// Testbench for frame_plane_layout_top: random layout requests checked against a local predictor.
`timescale 1ns / 1ps

module frame_plane_layout_top_tb;

  localparam int unsigned ALIGN      = 64;
  localparam int unsigned MAX_DIM    = 4096;
  localparam int          NUM_FIELDS = 12;
  localparam int          MAX_REPORT = 10;
  localparam int          PHASE_LEN  = 443;
  localparam int          END_WAIT   = 20;

  typedef struct packed {
    logic                         status;
    logic [fpl_pkg::DIM_W-1:0]    padded_height;
    logic [fpl_pkg::DIM_W-1:0]    chroma_width;
    logic [fpl_pkg::DIM_W-1:0]    chroma_height;
    logic [fpl_pkg::STRIDE_W-1:0] luma_stride;
    logic [fpl_pkg::CSTR_W-1:0]   first_chroma_stride;
    logic [fpl_pkg::CSTR_W-1:0]   second_chroma_stride;
    logic [fpl_pkg::OFF1_W-1:0]   first_chroma_offset;
    logic [fpl_pkg::OFF2_W-1:0]   second_chroma_offset;
    logic [fpl_pkg::SIZE_W-1:0]   padded_size;
    logic [fpl_pkg::SIZE_W-1:0]   tight_size;
    logic                         tight_valid;
  } layout_t;

  typedef struct {
    logic [fpl_pkg::FMT_W-1:0] fmt;
    logic [fpl_pkg::DIM_W-1:0] width;
    logic [fpl_pkg::DIM_W-1:0] height;
    int                        phase;
    bit                        drain;  // hold off until all outstanding layouts are back
  } layout_req_t;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [31:0]  s_axis_tdata;
  logic [2:0]   s_axis_tuser;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [191:0] m_axis_tdata;
  logic [1:0]   m_axis_tuser;

  layout_req_t req_q[$];
  layout_t     expected_layouts[$];
  int          mismatch_cnt;
  bit          s_taken;
  int          snd_idle_pct;
  int          rcv_idle_pct;
  int          snd_pct_by_phase[3] = '{16, 77, 0};
  int          rcv_pct_by_phase[3] = '{77, 16, 0};
  string       field_names[NUM_FIELDS] = '{"status", "padded_height", "chroma_width",
    "chroma_height", "luma_stride", "first_chroma_stride", "second_chroma_stride",
    "first_chroma_offset", "second_chroma_offset", "padded_size", "tight_size",
    "tight_valid"};

  frame_plane_layout_top #(
    .ALIGN  (ALIGN),
    .MAX_DIM(MAX_DIM)
  ) u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  always begin
    clk_i = 1'b1;
    #10;
    clk_i = 1'b0;
    #10;
  end

  function automatic longint unsigned pad_up(longint unsigned len);
    return ((len + ALIGN - 1) / ALIGN) * ALIGN;
  endfunction

  function automatic layout_t predict_layout(logic [fpl_pkg::FMT_W-1:0] fmt,
                                             logic [fpl_pkg::DIM_W-1:0] w_in,
                                             logic [fpl_pkg::DIM_W-1:0] h_in);
    layout_t         r;
    longint unsigned w, h, hp, s0, s1, cw, ch, off1, off2, tight;
    bit              tv;
    r = '0;
    if (fmt > fpl_pkg::FMT_YUV420) begin
      r.status = fpl_pkg::ST_BAD_FMT;
      return r;
    end
    w = (w_in > MAX_DIM) ? 64'(MAX_DIM) : 64'(w_in);
    h = (h_in > MAX_DIM) ? 64'(MAX_DIM) : 64'(h_in);
    hp = pad_up(h);
    s0 = pad_up(w);
    s1 = 0;
    cw = 0;
    ch = 0;
    off1 = 0;
    off2 = 0;
    tight = 0;
    tv = 1'b1;
    case (fpl_pkg::fmt_e'(fmt))
      fpl_pkg::FMT_ARGB: begin
        s0 = s0 * 4;
        tight = w * h * 4;
      end
      fpl_pkg::FMT_YUYV, fpl_pkg::FMT_YVYU: begin
        s0 = s0 * 2;
        tv = 1'b0;
      end
      fpl_pkg::FMT_YUV444: begin
        s1 = s0;
        cw = w;
        ch = hp;
        off1 = s0 * hp;
        off2 = off1 * 2;
        tight = w * h * 3;
      end
      fpl_pkg::FMT_YUV422P: begin
        s1 = s0 / 2;
        cw = w / 2;
        ch = hp;
        off1 = s0 * hp;
        off2 = off1 + s1 * ch;
        tight = w * h + (w / 2) * h * 2;
      end
      default: begin
        s1 = s0 / 2;
        cw = w / 2;
        ch = hp / 2;
        off1 = s0 * hp;
        off2 = off1 + s1 * ch;
        tight = w * h + (w / 2) * (h / 2) * 2;
      end
    endcase
    if (w == 0 || h == 0) tv = 1'b0;
    r.status               = fpl_pkg::ST_OK;
    r.padded_height        = hp[fpl_pkg::DIM_W-1:0];
    r.chroma_width         = cw[fpl_pkg::DIM_W-1:0];
    r.chroma_height        = ch[fpl_pkg::DIM_W-1:0];
    r.luma_stride          = s0[fpl_pkg::STRIDE_W-1:0];
    r.first_chroma_stride  = s1[fpl_pkg::CSTR_W-1:0];
    r.second_chroma_stride = s1[fpl_pkg::CSTR_W-1:0];
    r.first_chroma_offset  = off1[fpl_pkg::OFF1_W-1:0];
    r.second_chroma_offset = off2[fpl_pkg::OFF2_W-1:0];
    r.padded_size          = fpl_pkg::SIZE_W'(s0 * hp + 2 * s1 * ch);
    r.tight_size           = tv ? tight[fpl_pkg::SIZE_W-1:0] : '0;
    r.tight_valid          = tv;
    return r;
  endfunction

  function automatic longint unsigned field_of(layout_t l, int idx);
    case (idx)
      0:       return 64'(l.status);
      1:       return 64'(l.padded_height);
      2:       return 64'(l.chroma_width);
      3:       return 64'(l.chroma_height);
      4:       return 64'(l.luma_stride);
      5:       return 64'(l.first_chroma_stride);
      6:       return 64'(l.second_chroma_stride);
      7:       return 64'(l.first_chroma_offset);
      8:       return 64'(l.second_chroma_offset);
      9:       return 64'(l.padded_size);
      10:      return 64'(l.tight_size);
      default: return 64'(l.tight_valid);
    endcase
  endfunction

  // Mostly legal sizes, with alignment edges, tiny frames and out-of-range values mixed in
  function automatic int rand_dim();
    int unsigned sel;
    sel = $urandom_range(9);
    if (sel < 6) return $urandom_range(MAX_DIM, 1);
    if (sel < 7) return $urandom_range(200, 1);
    if (sel < 9) return $urandom_range(MAX_DIM / ALIGN, 1) * ALIGN + $urandom_range(2) - 1;
    return $urandom_range((1 << fpl_pkg::DIM_W) - 1);
  endfunction

  task automatic add_req(int fmt, int w, int h, int phase, bit drain);
    layout_req_t r;
    r.fmt    = fpl_pkg::FMT_W'(fmt);
    r.width  = fpl_pkg::DIM_W'(w);
    r.height = fpl_pkg::DIM_W'(h);
    r.phase  = phase;
    r.drain  = drain;
    req_q.push_back(r);
  endtask

  // Sender: new transfer offered at the falling edge once the previous one went through
  always @(negedge clk_i) begin
    layout_req_t req;
    if (rst_ni) begin
      if (!s_axis_tvalid || s_taken) begin
        if (req_q.size() == 0 || (req_q[0].drain && expected_layouts.size() != 0) ||
            $urandom_range(99) < snd_idle_pct) begin
          s_axis_tvalid <= 1'b0;
        end else begin
          req = req_q.pop_front();
          snd_idle_pct = snd_pct_by_phase[req.phase];
          rcv_idle_pct <= rcv_pct_by_phase[req.phase];
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {6'b0, req.height, req.width};
          s_axis_tuser  <= req.fmt;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) m_axis_tready <= ($urandom_range(99) >= rcv_idle_pct);
  end

  // Output is checked before the new request is queued: an output leaving
  // at the same edge is always older.
  always @(posedge clk_i) begin
    layout_t got;
    layout_t want;
    bit      bad;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.status               = m_axis_tuser[0];
        got.tight_valid          = m_axis_tuser[1];
        got.padded_height        = m_axis_tdata[12:0];
        got.chroma_width         = m_axis_tdata[25:13];
        got.chroma_height        = m_axis_tdata[38:26];
        got.luma_stride          = m_axis_tdata[53:39];
        got.first_chroma_stride  = m_axis_tdata[66:54];
        got.second_chroma_stride = m_axis_tdata[79:67];
        got.first_chroma_offset  = m_axis_tdata[104:80];
        got.second_chroma_offset = m_axis_tdata[130:105];
        got.padded_size          = m_axis_tdata[157:131];
        got.tight_size           = m_axis_tdata[184:158];
        if (expected_layouts.size() == 0) begin
          mismatch_cnt++;
          if (mismatch_cnt <= MAX_REPORT)
            $display("%0t: unexpected output transfer, tdata=%h tuser=%b",
                     $realtime, m_axis_tdata, m_axis_tuser);
        end else begin
          want = expected_layouts.pop_front();
          bad = 1'b0;
          for (int i = 0; i < NUM_FIELDS; i++) begin
            if (field_of(got, i) != field_of(want, i)) begin
              if (!bad) mismatch_cnt++;
              bad = 1'b1;
              if (mismatch_cnt <= MAX_REPORT)
                $display("%0t: %s expected %0d got %0d", $realtime, field_names[i],
                         field_of(want, i), field_of(got, i));
            end
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready)
        expected_layouts.push_back(predict_layout(s_axis_tuser, s_axis_tdata[12:0],
                                                  s_axis_tdata[25:13]));
    end
    s_taken <= rst_ni && s_axis_tvalid && s_axis_tready;
  end

  initial begin
    #5_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    mismatch_cnt  = 0;
    snd_idle_pct  = snd_pct_by_phase[0];
    rcv_idle_pct  = rcv_pct_by_phase[0];

    // every format at the smallest and largest legal frame
    for (int f = int'(fpl_pkg::FMT_ARGB); f <= int'(fpl_pkg::FMT_YUV420); f++) begin
      add_req(f, 1, 1, 0, 1'b0);
      add_req(f, MAX_DIM, MAX_DIM, 0, 1'b0);
    end
    // unknown format codes
    add_req(int'(fpl_pkg::FMT_YUV420) + 1, rand_dim(), rand_dim(), 0, 1'b0);
    add_req(int'(fpl_pkg::FMT_YUV420) + 2, (1 << fpl_pkg::DIM_W) - 1,
            (1 << fpl_pkg::DIM_W) - 1, 0, 1'b0);
    // zero dimensions
    add_req(int'(fpl_pkg::FMT_YUV420), 0, 100, 0, 1'b0);
    add_req(int'(fpl_pkg::FMT_YUV444), 100, 0, 0, 1'b0);
    // oversized dimensions get clamped
    add_req(int'(fpl_pkg::FMT_YUV422P), (1 << fpl_pkg::DIM_W) - 1,
            (1 << fpl_pkg::DIM_W) - 1, 0, 1'b0);
    add_req(int'(fpl_pkg::FMT_ARGB), MAX_DIM + 1, 100, 0, 1'b0);
    // odd sizes around the alignment step
    add_req(int'(fpl_pkg::FMT_YUV420), ALIGN - 1, ALIGN + 1, 0, 1'b0);
    add_req(int'(fpl_pkg::FMT_YUV420), ALIGN + 1, 2 * ALIGN - 1, 0, 1'b0);
    add_req(int'(fpl_pkg::FMT_YUYV), ALIGN, 1, 0, 1'b0);

    for (int p = 0; p < 3; p++)
      for (int i = 0; i < PHASE_LEN; i++)
        add_req($urandom_range((1 << fpl_pkg::FMT_W) - 1), rand_dim(), rand_dim(), p,
                i == 0);

    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    while (req_q.size() != 0 || s_axis_tvalid || expected_layouts.size() != 0)
      @(posedge clk_i);
    repeat (END_WAIT) @(posedge clk_i);
    if (mismatch_cnt == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
